>>> sv/mrts_pkg.sv
// shared types and constants of the motor round-trip sequencer
package mrts_pkg;

  // sequence phase, also the run_state code on the result channel
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TO_SENSOR = 3'd1,
    PH_BACK      = 3'd2,
    PH_DONE      = 3'd3,
    PH_FAULT     = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    SERVO_NONE   = 2'd0,
    SERVO_TURN   = 2'd1,
    SERVO_RETURN = 2'd2
  } servo_req_t;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PWM_TOP       = 3'd0,
    CFG_LONG_PRESS    = 3'd1,
    CFG_SENSOR_TMO    = 3'd2,
    CFG_ROUND_TRIPS   = 3'd3,
    CFG_SERVO_DELAY   = 3'd4
  } cfg_index_t;

  // register values after reset
  localparam logic [15:0] RST_PWM_TOP       = 16'd1199;
  localparam logic [15:0] RST_LONG_PRESS    = 16'd1500;
  localparam logic [15:0] RST_SENSOR_TMO    = 16'd10000;
  localparam logic [7:0]  RST_ROUND_TRIPS   = 8'd5;
  localparam logic [15:0] RST_SERVO_DELAY   = 16'd1000;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  // duty of each gear in permille
  localparam logic [9:0] PERMILLE_LOW  = 10'd300;
  localparam logic [9:0] PERMILLE_MID  = 10'd600;
  localparam logic [9:0] PERMILLE_FULL = 10'd1000;

  // x / 1000 = (x >> 3) / 125; /125 as multiply by ceil(2^30 / 125) then >> 30,
  // exact for (x >> 3) below 2^23
  localparam int unsigned PROD_W     = 26;
  localparam int unsigned RECIP_W    = 24;
  localparam logic [RECIP_W-1:0] RECIP_125 = 24'd8589935;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned QPROD_W     = (PROD_W - 3) + RECIP_W;
  localparam int unsigned QUOT_W      = 17;

  // fields that travel down the compare pipeline with each beat
  typedef struct packed {
    logic [2:0]  run_state;
    logic        motor_running;
    logic        direction_forward;
    logic [1:0]  speed_gear;
    logic [7:0]  trips_done;
    logic [15:0] measured_ms;
    logic [1:0]  servo_request;
    logic        drive_fwd;
  } stage_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == SAT16) ? v : v + 16'd1;
  endfunction

  function automatic logic [9:0] gear_permille(input logic [1:0] g);
    case (g)
      2'd1:    return PERMILLE_MID;
      2'd2:    return PERMILLE_FULL;
      default: return PERMILLE_LOW;
    endcase
  endfunction

  // gear cycles 30 -> 60 -> 100 -> 30 percent, code 3 behaves as 30 percent
  function automatic logic [1:0] gear_step(input logic [1:0] g);
    case (g)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      2'd2:    return 2'd0;
      default: return 2'd1;
    endcase
  endfunction

endpackage

>>> sv/mrts_if.sv
// channel interfaces of the motor round-trip sequencer

interface mrts_in_if;
  logic valid;
  logic ready;
  logic button_pressed;
  logic sensor_active;

  modport source (output valid, output button_pressed, output sensor_active, input ready);
  modport sink   (input valid, input button_pressed, input sensor_active, output ready);
endinterface

interface mrts_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] forward_compare;
  logic [15:0] reverse_compare;
  logic [2:0]  run_state;
  logic        motor_running;
  logic        direction_forward;
  logic [1:0]  speed_gear;
  logic [7:0]  trips_done;
  logic [15:0] measured_ms;
  logic [1:0]  servo_request;

  modport source (
    output valid, output forward_compare, output reverse_compare, output run_state,
    output motor_running, output direction_forward, output speed_gear,
    output trips_done, output measured_ms, output servo_request, input ready
  );
  modport sink (
    input valid, input forward_compare, input reverse_compare, input run_state,
    input motor_running, input direction_forward, input speed_gear,
    input trips_done, input measured_ms, input servo_request, output ready
  );
endinterface

interface mrts_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/motor_round_trip_sequencer.sv
// motor round-trip sequencer: button, sensor and timing rules plus compare pipeline
//
//  channel | dir | payload                                   | beat taken when
//  --------+-----+-------------------------------------------+----------------------
//  feed    | in  | button_pressed, sensor_active (one tick)  | feed.valid & ready
//  result  | out | compares, run_state, flags, gear, counts  | result.valid & ready
//  cfg     | in  | index (3 bit), data (16 bit)              | cfg.valid (ready out of reset)
//
//  one feed beat per cycle sustained while result.ready stays high; all sequencing
//  state updates in the cycle the beat is taken, and the result leaves through the
//  compare pipeline (permille multiply, reciprocal multiply for /1000, cap and select)
//  rst is synchronous, active high; it loads the register reset values and idles
//  every pipeline stage; a stalled result holds its stage and earlier stages keep
//  filling, so feed.ready drops only once all four stages are occupied
module motor_round_trip_sequencer (
  input  logic              clk,
  input  logic              rst,
  mrts_in_if.sink           feed,
  mrts_out_if.source        result,
  mrts_cfg_if.sink          cfg
);

  // ---------------------------------------------------------------- config
  logic [15:0] pwm_top;
  logic [15:0] long_press_ms;
  logic [15:0] sensor_timeout_ms;
  logic [7:0]  round_trips;
  logic [15:0] servo_delay_ms;

  // no config beat is taken while in reset
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_top           <= mrts_pkg::RST_PWM_TOP;
      long_press_ms     <= mrts_pkg::RST_LONG_PRESS;
      sensor_timeout_ms <= mrts_pkg::RST_SENSOR_TMO;
      round_trips       <= mrts_pkg::RST_ROUND_TRIPS;
      servo_delay_ms    <= mrts_pkg::RST_SERVO_DELAY;
    end else if (cfg.valid) begin
      case (mrts_pkg::cfg_index_t'(cfg.index))
        mrts_pkg::CFG_PWM_TOP:     pwm_top           <= cfg.data;
        mrts_pkg::CFG_LONG_PRESS:  long_press_ms     <= cfg.data;
        mrts_pkg::CFG_SENSOR_TMO:  sensor_timeout_ms <= cfg.data;
        mrts_pkg::CFG_ROUND_TRIPS: round_trips       <= cfg.data[7:0];
        mrts_pkg::CFG_SERVO_DELAY: servo_delay_ms    <= cfg.data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- pipeline handshake
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  // a stage loads when it is empty or its content moves on this cycle
  assign en4 = !v4 || result.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  // no feed beat is taken while in reset
  assign feed.ready = en1 && !rst;

  logic take;
  assign take = feed.valid && feed.ready;

  // ---------------------------------------------------------------- sequencing state
  mrts_pkg::phase_t phase, phase_next;
  logic        running_flag, running_flag_next;
  logic        forward_flag, forward_flag_next;
  logic [1:0]  gear, gear_next;
  logic        button_prev, button_prev_next;
  logic [15:0] press_elapsed, press_elapsed_next;
  logic        long_handled, long_handled_next;
  logic        sensor_prev, sensor_prev_next;
  logic [15:0] phase_elapsed, phase_elapsed_next;
  logic [15:0] travel_ms, travel_ms_next;
  logic [7:0]  trip_count, trip_count_next;
  logic        servo_turned, servo_turned_next;
  logic        servo_pending, servo_pending_next;
  logic [15:0] servo_elapsed, servo_elapsed_next;

  // side results of the tick, used by the output block
  logic drive_fwd;     // direction the motor is driven with this tick
  logic servo_fire;    // turn request raised this tick
  logic servo_back;    // return request raised this tick

  logic [7:0] trip_inc;
  logic       sensor_edge;

  always_comb begin
    // counters advance at the start of every tick
    press_elapsed_next = mrts_pkg::sat_inc(press_elapsed);
    phase_elapsed_next = mrts_pkg::sat_inc(phase_elapsed);
    servo_elapsed_next = mrts_pkg::sat_inc(servo_elapsed);
    phase_next         = phase;
    running_flag_next  = running_flag;
    forward_flag_next  = forward_flag;
    gear_next          = gear;
    long_handled_next  = long_handled;
    sensor_prev_next   = sensor_prev;
    travel_ms_next     = travel_ms;
    trip_count_next    = trip_count;
    servo_turned_next  = servo_turned;
    servo_pending_next = servo_pending;
    servo_fire         = 1'b0;
    servo_back         = 1'b0;
    trip_inc           = trip_count + 8'd1;
    sensor_edge        = !sensor_prev && feed.sensor_active;

    // button press edge restarts the hold timer
    if (feed.button_pressed && !button_prev) begin
      press_elapsed_next = '0;
      long_handled_next  = 1'b0;
    end
    // long press starts a sequence when the motor is stopped
    if (feed.button_pressed && !long_handled_next && press_elapsed_next >= long_press_ms) begin
      long_handled_next = 1'b1;
      if (!running_flag) begin
        running_flag_next  = 1'b1;
        phase_next         = mrts_pkg::PH_TO_SENSOR;
        phase_elapsed_next = '0;
        travel_ms_next     = '0;
        trip_count_next    = '0;
        servo_turned_next  = 1'b0;
        servo_pending_next = 1'b0;
        servo_elapsed_next = '0;
        forward_flag_next  = 1'b1;
      end
    end
    // short press release steps the gear
    if (!feed.button_pressed && button_prev && press_elapsed_next < long_press_ms) begin
      gear_next = mrts_pkg::gear_step(gear);
    end
    button_prev_next = feed.button_pressed;
    trip_inc         = trip_count_next + 8'd1;

    // drive uses the direction held before any reversal in this tick
    drive_fwd = forward_flag_next;

    case (phase_next)
      mrts_pkg::PH_IDLE: ;
      mrts_pkg::PH_TO_SENSOR: begin
        sensor_prev_next = feed.sensor_active;
        if (sensor_edge) begin
          travel_ms_next = phase_elapsed_next;
          if (!servo_turned_next) begin
            servo_pending_next = 1'b1;
            servo_elapsed_next = '0;
          end
          forward_flag_next  = !forward_flag_next;
          phase_elapsed_next = '0;
          phase_next         = mrts_pkg::PH_BACK;
        end else if (phase_elapsed_next > sensor_timeout_ms) begin
          phase_next = mrts_pkg::PH_FAULT;
        end
      end
      mrts_pkg::PH_BACK: begin
        if (phase_elapsed_next >= travel_ms_next) begin
          trip_count_next = trip_inc;
          if (trip_inc >= round_trips) begin
            phase_next = mrts_pkg::PH_DONE;
          end else begin
            forward_flag_next  = !forward_flag_next;
            phase_elapsed_next = '0;
            phase_next         = mrts_pkg::PH_TO_SENSOR;
          end
        end
      end
      mrts_pkg::PH_DONE: begin
        running_flag_next = 1'b0;
        if (servo_turned_next) begin
          servo_back        = 1'b1;
          servo_turned_next = 1'b0;
        end
        servo_pending_next = 1'b0;
      end
      mrts_pkg::PH_FAULT: begin
        running_flag_next  = 1'b0;
        servo_pending_next = 1'b0;
      end
      default: begin
        phase_next        = mrts_pkg::PH_IDLE;
        running_flag_next = 1'b0;
      end
    endcase

    // servo turn once the delay after the first sensor edge has run out
    if (servo_pending_next && !servo_turned_next && servo_elapsed_next >= servo_delay_ms) begin
      servo_fire         = 1'b1;
      servo_turned_next  = 1'b1;
      servo_pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= mrts_pkg::PH_IDLE;
      running_flag  <= 1'b0;
      forward_flag  <= 1'b1;
      gear          <= 2'd0;
      button_prev   <= 1'b0;
      press_elapsed <= '0;
      long_handled  <= 1'b0;
      sensor_prev   <= 1'b1;  // a beam blocked at start is no edge
      phase_elapsed <= '0;
      travel_ms     <= '0;
      trip_count    <= '0;
      servo_turned  <= 1'b0;
      servo_pending <= 1'b0;
      servo_elapsed <= '0;
    end else if (take) begin
      phase         <= phase_next;
      running_flag  <= running_flag_next;
      forward_flag  <= forward_flag_next;
      gear          <= gear_next;
      button_prev   <= button_prev_next;
      press_elapsed <= press_elapsed_next;
      long_handled  <= long_handled_next;
      sensor_prev   <= sensor_prev_next;
      phase_elapsed <= phase_elapsed_next;
      travel_ms     <= travel_ms_next;
      trip_count    <= trip_count_next;
      servo_turned  <= servo_turned_next;
      servo_pending <= servo_pending_next;
      servo_elapsed <= servo_elapsed_next;
    end
  end

  // ---------------------------------------------------------------- result fields of the tick
  mrts_pkg::stage_t s1_next;

  always_comb begin
    s1_next.run_state         = phase_next;
    s1_next.motor_running     = running_flag_next;
    s1_next.direction_forward = forward_flag_next;
    s1_next.speed_gear        = gear_next;
    s1_next.trips_done        = trip_count_next;
    s1_next.measured_ms       = travel_ms_next;
    s1_next.drive_fwd         = drive_fwd;
    // a turn request in the same tick overrides a return request
    if (servo_fire) begin
      s1_next.servo_request = mrts_pkg::SERVO_TURN;
    end else if (servo_back) begin
      s1_next.servo_request = mrts_pkg::SERVO_RETURN;
    end else begin
      s1_next.servo_request = mrts_pkg::SERVO_NONE;
    end
  end

  // ---------------------------------------------------------------- compare pipeline
  mrts_pkg::stage_t s1, s2, s3;
  logic [mrts_pkg::PROD_W-1:0]  s2_prod;
  logic [mrts_pkg::QUOT_W-1:0]  s3_quot;
  logic [16:0]                  top_p1;
  logic [mrts_pkg::QPROD_W-1:0] qprod;
  logic [15:0]                  cmp_val;
  logic [15:0]                  fwd_cmp, rev_cmp;
  mrts_pkg::stage_t             s4;

  assign top_p1 = {1'b0, pwm_top} + 17'd1;
  assign qprod  = {{mrts_pkg::RECIP_W{1'b0}}, s2_prod[mrts_pkg::PROD_W-1:3]}
                * {{(mrts_pkg::PROD_W-3){1'b0}}, mrts_pkg::RECIP_125};
  // full gear lands at top plus one, capped back to top
  assign cmp_val = (s3_quot > {1'b0, pwm_top}) ? pwm_top : s3_quot[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= take;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1 <= s1_next;
    end
    if (en2 && v1) begin
      s2      <= s1;
      // (top + 1) * permille, at most 65536000
      s2_prod <= {{(mrts_pkg::PROD_W-17){1'b0}}, top_p1}
               * {{(mrts_pkg::PROD_W-10){1'b0}}, mrts_pkg::gear_permille(s1.speed_gear)};
    end
    if (en3 && v2) begin
      s3      <= s2;
      s3_quot <= qprod[mrts_pkg::RECIP_SHIFT +: mrts_pkg::QUOT_W];
    end
    if (en4 && v3) begin
      s4 <= s3;
      // motor stopped gives both bridge inputs off
      fwd_cmp <= (s3.motor_running && s3.drive_fwd)  ? cmp_val : 16'd0;
      rev_cmp <= (s3.motor_running && !s3.drive_fwd) ? cmp_val : 16'd0;
    end
  end

  assign result.valid             = v4;
  assign result.forward_compare   = fwd_cmp;
  assign result.reverse_compare   = rev_cmp;
  assign result.run_state         = s4.run_state;
  assign result.motor_running     = s4.motor_running;
  assign result.direction_forward = s4.direction_forward;
  assign result.speed_gear        = s4.speed_gear;
  assign result.trips_done        = s4.trips_done;
  assign result.measured_ms       = s4.measured_ms;
  assign result.servo_request     = s4.servo_request;

`ifndef SYNTHESIS
  // the motor only runs inside a sequence
  a_run_not_idle: assert property (@(posedge clk) disable iff (rst)
    !(running_flag && phase == mrts_pkg::PH_IDLE))
    else $error("running flag set in idle phase");

  // a pending turn never coexists with a completed turn
  a_servo_excl: assert property (@(posedge clk) disable iff (rst)
    !(servo_turned && servo_pending))
    else $error("servo pending and turned together");

  // never both bridge inputs driven
  a_bridge_excl: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (fwd_cmp == 16'd0 || rev_cmp == 16'd0))
    else $error("both bridge compares nonzero");

  // stopped motor gives zero compares
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    (v4 && !s4.motor_running) |-> (fwd_cmp == 16'd0 && rev_cmp == 16'd0))
    else $error("compare nonzero while stopped");

  // gear stays within its three settings
  a_gear_range: assert property (@(posedge clk) disable iff (rst)
    gear != 2'd3)
    else $error("gear code out of range");
`endif

endmodule

>>> test/motor_round_trip_sequencer_test.sv
// testbench of the motor round-trip sequencer: tick stimulus, sequencer prediction, beat checks
module motor_round_trip_sequencer_test;

  // cycles with no beat on any channel before the run is called hung
  localparam int QUIET_LIMIT  = 4000;
  // receiver hold-off used to fill the compare pipeline and stall the feed
  localparam int LONG_HOLD    = 80;
  // settle time after the last result has left the four-stage pipeline
  localparam int DRAIN_CYCLES = 12;
  // index with no register behind it, writes must be ignored
  localparam logic [mrts_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // one millisecond tick as offered on the feed channel
  typedef struct packed {
    logic button;
    logic sensor;
  } tick_t;

  // one result beat as the sequencer should produce it
  typedef struct packed {
    logic [15:0]          forward_compare;
    logic [15:0]          reverse_compare;
    mrts_pkg::phase_t     run_state;
    logic                 motor_running;
    logic                 direction_forward;
    logic [1:0]           speed_gear;
    logic [7:0]           trips_done;
    logic [15:0]          measured_ms;
    mrts_pkg::servo_req_t servo_request;
  } sequencer_out_t;

  logic clk;
  logic rst;

  mrts_in_if  feed_if ();
  mrts_out_if result_if ();
  mrts_cfg_if cfg_if ();

  motor_round_trip_sequencer i_dut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  // ticks waiting to be offered, head is the one on the feed channel
  tick_t          pending_ticks[$];
  // predicted result beats, oldest first
  sequencer_out_t expected_outputs[$];

  int  queued_ticks   = 0;
  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  bit  feed_taken;
  int  sender_idle_pct = 0;
  int  sink_stall_pct  = 0;
  int  holds_asked     = 0;
  int  holds_done      = 0;
  int  hold_left       = 0;

  // register values the stimulus plans around
  int  plan_long_ms    = 1500;
  int  plan_timeout_ms = 10000;
  int  plan_trips      = 5;

  // predictor copy of the registers
  logic [15:0] cfg_pwm_top;
  logic [15:0] cfg_long_press;
  logic [15:0] cfg_sensor_tmo;
  logic [7:0]  cfg_round_trips;
  logic [15:0] cfg_servo_delay;

  // predictor copy of the sequencer state
  mrts_pkg::phase_t seq_phase;
  logic        running;
  logic        dir_forward;
  logic [1:0]  gear_sel;
  logic        button_last;
  logic [15:0] press_ms;
  logic        long_seen;
  logic        sensor_last;
  logic [15:0] phase_ms;
  logic [15:0] travel_ms;
  logic [7:0]  trip_count;
  logic        servo_turned;
  logic        servo_pending;
  logic [15:0] servo_ms;
  logic [15:0] fwd_cmp;
  logic [15:0] rev_cmp;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  task automatic reset_predictor();
    cfg_pwm_top     = mrts_pkg::RST_PWM_TOP;
    cfg_long_press  = mrts_pkg::RST_LONG_PRESS;
    cfg_sensor_tmo  = mrts_pkg::RST_SENSOR_TMO;
    cfg_round_trips = mrts_pkg::RST_ROUND_TRIPS;
    cfg_servo_delay = mrts_pkg::RST_SERVO_DELAY;
    seq_phase     = mrts_pkg::PH_IDLE;
    running       = 1'b0;
    dir_forward   = 1'b1;
    gear_sel      = 2'd0;
    button_last   = 1'b0;
    press_ms      = 16'd0;
    long_seen     = 1'b0;
    // starts as blocked so a beam already blocked at power-up is no edge
    sensor_last   = 1'b1;
    phase_ms      = 16'd0;
    travel_ms     = 16'd0;
    trip_count    = 8'd0;
    servo_turned  = 1'b0;
    servo_pending = 1'b0;
    servo_ms      = 16'd0;
    fwd_cmp       = 16'd0;
    rev_cmp       = 16'd0;
  endtask

  task automatic apply_register(logic [mrts_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
    case (idx)
      mrts_pkg::CFG_PWM_TOP:     cfg_pwm_top     = value;
      mrts_pkg::CFG_LONG_PRESS:  cfg_long_press  = value;
      mrts_pkg::CFG_SENSOR_TMO:  cfg_sensor_tmo  = value;
      mrts_pkg::CFG_ROUND_TRIPS: cfg_round_trips = value[7:0];
      mrts_pkg::CFG_SERVO_DELAY: cfg_servo_delay = value;
      default: ;
    endcase
  endtask

  // elapsed counters stick at all ones
  function automatic logic [15:0] bump_ms(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // (top + 1) * permille / 1000, capped at top; any other gear code runs at 30 percent
  function automatic logic [15:0] duty_compare(logic [1:0] g);
    int unsigned permille;
    int unsigned top;
    int unsigned c;
    permille = (g == 2'd1) ? 600 : (g == 2'd2) ? 1000 : 300;
    top = cfg_pwm_top;
    c = (top + 1) * permille / 1000;
    return (c > top) ? 16'(top) : 16'(c);
  endfunction

  task automatic drive_motor();
    if (dir_forward) begin
      fwd_cmp = duty_compare(gear_sel);
      rev_cmp = 16'd0;
    end else begin
      fwd_cmp = 16'd0;
      rev_cmp = duty_compare(gear_sel);
    end
  endtask

  task automatic stop_motor();
    fwd_cmp = 16'd0;
    rev_cmp = 16'd0;
  endtask

  // one millisecond tick: counters, button rules, sequence step, servo delay
  task automatic advance_sequencer(logic button, logic sensor);
    sequencer_out_t       o;
    logic                 sensor_edge;
    mrts_pkg::servo_req_t servo;
    servo    = mrts_pkg::SERVO_NONE;
    press_ms = bump_ms(press_ms);
    phase_ms = bump_ms(phase_ms);
    servo_ms = bump_ms(servo_ms);

    // press edge restarts the hold timer
    if (button && !button_last) begin
      press_ms  = 16'd0;
      long_seen = 1'b0;
    end
    // long press starts a sequence only when the motor is not running
    if (button && !long_seen && press_ms >= cfg_long_press) begin
      long_seen = 1'b1;
      if (!running) begin
        running       = 1'b1;
        seq_phase     = mrts_pkg::PH_TO_SENSOR;
        phase_ms      = 16'd0;
        travel_ms     = 16'd0;
        trip_count    = 8'd0;
        servo_turned  = 1'b0;
        servo_pending = 1'b0;
        servo_ms      = 16'd0;
        dir_forward   = 1'b1;
        drive_motor();
      end
    end
    // short press steps the gear; code 3 would step on to 60 percent
    if (!button && button_last && press_ms < cfg_long_press)
      gear_sel = 2'((int'(gear_sel) + 1) % 3);
    button_last = button;

    case (seq_phase)
      mrts_pkg::PH_IDLE: ;
      mrts_pkg::PH_TO_SENSOR: begin
        // the sensor is only sampled while driving toward it
        sensor_edge = !sensor_last && sensor;
        drive_motor();
        sensor_last = sensor;
        if (sensor_edge) begin
          travel_ms = phase_ms;
          if (!servo_turned) begin
            servo_pending = 1'b1;
            servo_ms      = 16'd0;
          end
          dir_forward = !dir_forward;
          phase_ms    = 16'd0;
          seq_phase   = mrts_pkg::PH_BACK;
        end else if (phase_ms > cfg_sensor_tmo) begin
          seq_phase = mrts_pkg::PH_FAULT;
        end
      end
      mrts_pkg::PH_BACK: begin
        drive_motor();
        if (phase_ms >= travel_ms) begin
          trip_count = trip_count + 8'd1;
          // zero round trips ends the sequence after the first trip
          if (trip_count >= cfg_round_trips) begin
            seq_phase = mrts_pkg::PH_DONE;
          end else begin
            dir_forward = !dir_forward;
            phase_ms    = 16'd0;
            seq_phase   = mrts_pkg::PH_TO_SENSOR;
          end
        end
      end
      mrts_pkg::PH_DONE: begin
        running = 1'b0;
        stop_motor();
        if (servo_turned) begin
          servo        = mrts_pkg::SERVO_RETURN;
          servo_turned = 1'b0;
        end
        servo_pending = 1'b0;
      end
      mrts_pkg::PH_FAULT: begin
        running = 1'b0;
        stop_motor();
        servo_pending = 1'b0;
      end
      default: begin
        seq_phase = mrts_pkg::PH_IDLE;
        running   = 1'b0;
        stop_motor();
      end
    endcase

    if (servo_pending && !servo_turned && servo_ms >= cfg_servo_delay) begin
      servo         = mrts_pkg::SERVO_TURN;
      servo_turned  = 1'b1;
      servo_pending = 1'b0;
    end

    if (!running)
      stop_motor();

    o.forward_compare   = fwd_cmp;
    o.reverse_compare   = rev_cmp;
    o.run_state         = seq_phase;
    o.motor_running     = running;
    o.direction_forward = dir_forward;
    o.speed_gear        = gear_sel;
    o.trips_done        = trip_count;
    o.measured_ms       = travel_ms;
    o.servo_request     = servo;
    expected_outputs.push_back(o);
  endtask

  // ---------------------------------------------------------------- beats

  // accepted feed and config beats update the predictor in beat order
  always @(posedge clk) begin
    feed_taken = 1'b0;
    if (rst) begin
      reset_predictor();
    end else begin
      if (cfg_if.valid && cfg_if.ready)
        apply_register(cfg_if.index, cfg_if.data);
      if (feed_if.valid && feed_if.ready) begin
        feed_taken = 1'b1;
        void'(pending_ticks.pop_front());
        advance_sequencer(feed_if.button_pressed, feed_if.sensor_active);
      end
    end
  end

  // feed driver: offers the queue head, holds it until taken, idles at random
  always @(negedge clk) begin
    if (rst) begin
      feed_if.valid <= 1'b0;
    end else if (!feed_if.valid || feed_taken) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        feed_if.valid          <= 1'b1;
        feed_if.button_pressed <= pending_ticks[0].button;
        feed_if.sensor_active  <= pending_ticks[0].sensor;
      end else begin
        feed_if.valid <= 1'b0;
      end
    end
  end

  // result ready: random stalls, plus a long hold-off when one is asked for
  always @(negedge clk) begin
    if (holds_done != holds_asked) begin
      hold_left  = LONG_HOLD;
      holds_done = holds_done + 1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic void check_field(string field, logic [31:0] actual, logic [31:0] wanted);
    if (actual != wanted) begin
      mismatch_count = mismatch_count + 1;
      $display("%0t %s: expected %0d, actual %0d", $time, field, wanted, actual);
    end
  endfunction

  // result monitor: each beat against the oldest prediction
  always @(posedge clk) begin
    sequencer_out_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_outputs.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        $display("%0t result beat with nothing expected: expected none, actual run_state %0d",
                 $time, result_if.run_state);
      end else begin
        want = expected_outputs.pop_front();
        check_field("forward_compare", 32'(result_if.forward_compare),
                    32'(want.forward_compare));
        check_field("reverse_compare", 32'(result_if.reverse_compare),
                    32'(want.reverse_compare));
        check_field("run_state", 32'(result_if.run_state), 32'(want.run_state));
        check_field("motor_running", 32'(result_if.motor_running), 32'(want.motor_running));
        check_field("direction_forward", 32'(result_if.direction_forward),
                    32'(want.direction_forward));
        check_field("speed_gear", 32'(result_if.speed_gear), 32'(want.speed_gear));
        check_field("trips_done", 32'(result_if.trips_done), 32'(want.trips_done));
        check_field("measured_ms", 32'(result_if.measured_ms), 32'(want.measured_ms));
        check_field("servo_request", 32'(result_if.servo_request), 32'(want.servo_request));
      end
    end
  end

  // watchdog: too long without any beat means the block is hung
  always @(posedge clk) begin
    if (rst || (feed_if.valid && feed_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL motor_round_trip_sequencer");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_ticks(logic button, logic sensor, int count);
    tick_t t;
    t.button = button;
    t.sensor = sensor;
    repeat (count) begin
      pending_ticks.push_back(t);
      queued_ticks = queued_ticks + 1;
    end
  endtask

  // button held for some ticks then released, sensor steady
  task automatic push_short_press(int hold);
    logic level;
    level = 1'($urandom_range(1));
    push_ticks(1'b1, level, hold);
    push_ticks(1'b0, level, 1);
  endtask

  task automatic push_noise();
    repeat ($urandom_range(1, 6))
      push_ticks(1'($urandom_range(1)), 1'($urandom_range(1)), 1);
  endtask

  // long press, then out-to-sensor and back legs with random travel times;
  // now and then released too early or left to run into the sensor timeout
  task automatic push_session();
    int hold;
    int travel;
    int legs;
    int span;
    hold = plan_long_ms + 1 + $urandom_range(2);
    if ($urandom_range(9) == 0)
      hold = (plan_long_ms > 0) ? plan_long_ms : 1;
    push_ticks(1'b1, 1'b1, hold);
    push_ticks(1'b0, 1'b1, 1);
    legs = (plan_trips == 0) ? 1 : (plan_trips > 4) ? $urandom_range(2, 5) : plan_trips;
    span = (plan_timeout_ms < 25) ? plan_timeout_ms : 25;
    repeat (legs) begin
      if ($urandom_range(3) == 0)
        push_short_press($urandom_range(1, 3));
      travel = $urandom_range(1, span);
      if (plan_timeout_ms <= 40 && $urandom_range(7) == 0)
        travel = plan_timeout_ms + 2;
      push_ticks(1'b0, 1'b0, travel);
      push_ticks(1'b0, 1'b1, 1 + $urandom_range(1));
      // back leg: sensor is ignored, mostly blocked so the next leg sees a clean edge
      repeat (travel + $urandom_range(1, 3))
        push_ticks(1'b0, $urandom_range(5) != 0, 1);
      push_ticks(1'b0, 1'b1, 1);
    end
    push_ticks(1'b0, 1'($urandom_range(1)), $urandom_range(2, 5));
  endtask

  task automatic run_random(int count);
    int stop_at;
    int pick;
    stop_at = queued_ticks + count;
    while (queued_ticks < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70 && plan_long_ms <= 16)
        push_session();
      else if (pick < 85)
        push_short_press($urandom_range(1, 20));
      else
        push_noise();
    end
  endtask

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 61; sink_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  sink_stall_pct = 61; end
      default:       begin sender_idle_pct = 14; sink_stall_pct = 14; end
    endcase
  endtask

  // wait for every tick to be taken and every result to come back
  task automatic drain_outputs();
    while (pending_ticks.size() != 0 || expected_outputs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // valid stays up across back-to-back writes; the configure task lowers it
  task automatic write_reg(logic [mrts_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic configure(int pwm, int long_ms, int tmo_ms, logic [15:0] trips_word,
                           int delay_ms);
    write_reg(mrts_pkg::CFG_PWM_TOP, 16'(pwm));
    write_reg(mrts_pkg::CFG_LONG_PRESS, 16'(long_ms));
    write_reg(mrts_pkg::CFG_SENSOR_TMO, 16'(tmo_ms));
    write_reg(mrts_pkg::CFG_ROUND_TRIPS, trips_word);
    write_reg(mrts_pkg::CFG_SERVO_DELAY, 16'(delay_ms));
    @(negedge clk);
    cfg_if.valid    <= 1'b0;
    plan_long_ms    = long_ms;
    plan_timeout_ms = tmo_ms;
    plan_trips      = 32'(trips_word[7:0]);
  endtask

  task automatic run_phase(idle_mode_t mode, int count, bit squeeze);
    set_idling(mode);
    run_random(count);
    if (squeeze)
      holds_asked = holds_asked + 1;
    drain_outputs();
  endtask

  initial begin
    rst          = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: short presses walk the gear 30 -> 60 -> 100 -> 30 -> 60 percent
    set_idling(IDLE_NONE);
    push_short_press(1);
    push_short_press(2);
    push_short_press(3);
    push_short_press(1);
    run_random(40);
    drain_outputs();

    // top at maximum (compare capped), zero round trips, no servo delay
    write_reg(CFG_UNUSED_IDX, 16'($urandom));
    configure(65535, 3, 4, 16'd0, 0);
    set_idling(IDLE_SENDER);
    push_ticks(1'b0, 1'b1, 2);   // beam blocked before the start is no edge
    push_ticks(1'b1, 1'b1, 4);   // long press starts the sequence
    push_ticks(1'b0, 1'b0, 2);
    push_ticks(1'b0, 1'b1, 1);   // edge: turn request at once, reverse
    push_ticks(1'b0, 1'b1, 4);   // back by time, done after one trip, return request
    push_ticks(1'b1, 1'b1, 4);   // restart from done
    push_ticks(1'b0, 1'b0, 6);   // no edge: timeout fault
    run_phase(IDLE_SENDER, 150, 1'b0);

    // small top, long receiver hold-off with the sender running flat out
    configure(3, 5, 20, 16'd3, 7);
    run_phase(IDLE_NONE, 250, 1'b1);

    // zero top and hold time, tightest timeout, servo delay never reached
    configure(0, 0, 1, 16'd1, 65535);
    run_phase(IDLE_RECEIVER, 120, 1'b0);

    // timeout never fires, round trips at maximum keep the sequence running
    configure(1199, 2, 65535, 16'd255, 3);
    run_phase(IDLE_BOTH, 200, 1'b0);

    // long press never reached: every press is short
    configure(65535, 65535, 65534, 16'd1, 10);
    run_phase(IDLE_SENDER, 100, 1'b0);

    // random settings; upper byte of the round-trip word is junk
    for (int p = 0; p < 4; p++) begin
      configure($urandom_range(3, 65535), $urandom_range(1, 8), $urandom_range(6, 40),
                {8'($urandom), 8'($urandom_range(1, 4))}, $urandom_range(0, 30));
      case (p)
        0:       run_phase(IDLE_RECEIVER, 200, 1'b0);
        1:       run_phase(IDLE_BOTH, 200, 1'b0);
        2:       run_phase(IDLE_NONE, 200, 1'b1);
        default: run_phase(IDLE_SENDER, 200, 1'b0);
      endcase
    end

    if (mismatch_count == 0 && expected_outputs.size() == 0)
      $display("PASS motor_round_trip_sequencer");
    else
      $display("FAIL motor_round_trip_sequencer");
    $finish;
  end

endmodule

>>> files.f
sv/mrts_pkg.sv
sv/mrts_if.sv
sv/motor_round_trip_sequencer.sv
test/motor_round_trip_sequencer_test.sv
